### sv/swel_pkg.sv
// Shared constants and controller/datapath interface types for the event log.
`timescale 1ns / 1ps
`default_nettype none

package swel_pkg;

  // Ring depth used when the top level is not overridden.
  localparam int DEPTH_DEFAULT = 256;

  // Window length after reset: one day in minutes.
  localparam logic [31:0] WINDOW_RESET = 32'(24 * 60);

  // Field widths of one item.
  localparam int MINUTE_W = 32;
  localparam int INDEX_W  = 8;
  localparam int MODE_W   = 2;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PURGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted item, clear result flags
    logic rd_newest;  // read the newest entry
    logic rd_oldest;  // read the oldest entry
    logic rd_index;   // read the entry at the latched logical index
    logic write;      // append the latched minute
    logic drop;       // retire the oldest entry
    logic clear;      // empty the ring
    logic capture;    // take read data as the read result
    logic finish;     // move the result into the output register
  } swel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic              idx_ok;   // latched index lies below the entry count
    logic              dup;      // read data equals the latched minute
    logic              too_old;  // read data is older than the window
    logic              out_free; // output register can take a result
  } swel_stat_t;

endpackage

`default_nettype wire

### sv/swel_ctrl.sv
// Controller state machine sequencing each operation of the event log.
`timescale 1ns / 1ps
`default_nettype none

module swel_ctrl
  import swel_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire swel_stat_t stat,
  output swel_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DISPATCH  = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_PURGE_RD  = 3'd3;
  localparam logic [2:0] ST_PURGE_CMP = 3'd4;
  localparam logic [2:0] ST_READ_CAP  = 3'd5;
  localparam logic [2:0] ST_FINISH    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_ADD: begin
            if (stat.empty) begin
              cmd.write  = 1'b1;
              state_next = ST_PURGE_RD;
            end else begin
              cmd.rd_newest = 1'b1;
              state_next    = ST_DUP;
            end
          end
          MODE_PURGE: begin
            state_next = ST_PURGE_RD;
          end
          MODE_READ: begin
            if (stat.idx_ok) begin
              cmd.rd_index = 1'b1;
              state_next   = ST_READ_CAP;
            end else begin
              state_next = ST_FINISH;
            end
          end
          MODE_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_FINISH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_DUP: begin
        cmd.write  = !stat.dup;
        state_next = ST_PURGE_RD;
      end
      ST_PURGE_RD: begin
        if (stat.empty) begin
          state_next = ST_FINISH;
        end else begin
          cmd.rd_oldest = 1'b1;
          state_next    = ST_PURGE_CMP;
        end
      end
      ST_PURGE_CMP: begin
        if (stat.too_old) begin
          cmd.drop   = 1'b1;
          state_next = ST_PURGE_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_READ_CAP: begin
        cmd.capture = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/swel_datapath.sv
// Datapath of the event log: ring memory, pointers, window register, result register.
`timescale 1ns / 1ps
`default_nettype none

module swel_datapath
  import swel_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int OUT_W = 48
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [MINUTE_W-1:0] cfg_wr_data,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [MINUTE_W-1:0] in_minute,
  input  wire logic [INDEX_W-1:0]  in_index,
  input  wire swel_cmd_t           cmd,
  output swel_stat_t               stat,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_W-1:0]         m_tdata
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;
  localparam int SUM_W   = CMP_W + 1;
  localparam int RES_W   = COUNT_W + 2 + MINUTE_W;

  logic [MINUTE_W-1:0] mem [DEPTH];
  logic [MINUTE_W-1:0] rdata;

  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    wp;
  logic [COUNT_W-1:0]  count;
  logic [MINUTE_W-1:0] window;

  logic [MODE_W-1:0]   mode_q;
  logic [MINUTE_W-1:0] minute_q;
  logic [INDEX_W-1:0]  idx_q;
  logic                stored_q;
  logic                rvalid_q;
  logic [MINUTE_W-1:0] rminute_q;

  logic                full;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [PTR_W-1:0]    newest;
  logic [SUM_W-1:0]    idx_sum;
  logic [PTR_W-1:0]    idx_slot;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == COUNT_W'(DEPTH));
  assign newest  = (wp == '0) ? PTR_W'(DEPTH - 1) : wp - 1'b1;
  assign idx_sum = SUM_W'(head) + SUM_W'(idx_q);
  assign idx_slot = (idx_sum >= SUM_W'(DEPTH)) ? PTR_W'(idx_sum - SUM_W'(DEPTH))
                                               : PTR_W'(idx_sum);

  assign rd_en = cmd.rd_newest | cmd.rd_oldest | cmd.rd_index;

  always_comb begin
    rd_addr = head;
    if (cmd.rd_newest) begin
      rd_addr = newest;
    end else if (cmd.rd_index) begin
      rd_addr = idx_slot;
    end
  end

  // Ring storage, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wp] <= minute_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    stat.mode     = mode_q;
    stat.empty    = (count == '0);
    stat.idx_ok   = (SUM_W'(idx_q) < SUM_W'(count));
    stat.dup      = (rdata == minute_q);
    stat.too_old  = (rdata <= minute_q) && ((minute_q - rdata) > window);
    stat.out_free = !m_tvalid || m_tready;
  end

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window <= cfg_wr_data;
    end
  end

  // Ring pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      wp    <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= '0;
      wp    <= '0;
      count <= '0;
    end else if (cmd.write) begin
      wp <= ptr_inc(wp);
      if (full) begin
        head <= ptr_inc(head);
      end else begin
        count <= count + 1'b1;
      end
    end else if (cmd.drop) begin
      head  <= ptr_inc(head);
      count <= count - 1'b1;
    end
  end

  // Latched item and result flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= in_mode;
      minute_q  <= in_minute;
      idx_q     <= in_index;
      stored_q  <= 1'b0;
      rvalid_q  <= 1'b0;
      rminute_q <= '0;
    end else begin
      if (cmd.write) begin
        stored_q <= 1'b1;
      end
      if (cmd.capture) begin
        rvalid_q  <= 1'b1;
        rminute_q <= rdata;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= OUT_W'({rminute_q, rvalid_q, stored_q, count});
    end
  end

  logic [SUM_W-1:0] ring_sum;
  logic [PTR_W-1:0] ring_end;
  assign ring_sum = SUM_W'(head) + SUM_W'(count);
  assign ring_end = (ring_sum >= SUM_W'(DEPTH)) ? PTR_W'(ring_sum - SUM_W'(DEPTH))
                                                : PTR_W'(ring_sum);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count above ring depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    wp == ring_end)
    else $error("write pointer disagrees with oldest pointer plus count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (count == '0) && (head == '0) && (wp == '0))
    else $error("clear left entries in the ring");

  a_one_read: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_newest, cmd.rd_oldest, cmd.rd_index}))
    else $error("more than one memory read requested");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> (count != '0) && !cmd.write)
    else $error("drop from an empty ring or together with a write");

  a_width_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (RES_W <= OUT_W))
    else $error("result does not fit the output bus");

endmodule

`default_nettype wire

### sv/sliding_window_event_log.sv
// Top level of the sliding-window event log: stream ports, controller and datapath.
//
// The block keeps a ring of DEPTH event timestamps in minutes and answers one
// result transfer for every input transfer. Mode (tuser) selects the work: add an
// event (dropped if the newest entry already holds the same minute; the oldest
// entry is overwritten when the ring is full), purge entries older than the
// window at the given minute (stopping at an entry that lies in the future),
// read the entry at a logical index counted from the oldest, or clear the ring.
// Every add is followed by a purge at its own minute. The window length is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while the
// block is idle, which the block itself does not enforce. It resets to one day.
// Items are handled one at a time, paced by the controller and the ring memory
// with its registered read; a purge retires its entries one by one, each with
// one memory read and one age compare, and the retire that empties the ring
// ends the walk without a further read.
// A finished result sits in the output register, and the next item is accepted
// while it waits; the block stalls only if a second result is ready before the
// first is taken. The ring needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_event_log
  import swel_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int OUT_W = (($clog2(DEPTH + 1) + 2 + MINUTE_W + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // window_length register write
  input  wire logic                cfg_wr_en,
  input  wire logic [MINUTE_W-1:0] cfg_wr_data,
  // input items
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [39:0]         s_tdata,  // minute[31:0], index[39:32]
  input  wire logic [MODE_W-1:0]   s_tuser,  // mode[1:0]
  // result items
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_W-1:0]         m_tdata   // entry_count, stored, read_valid,
                                             // read_minute, zero pad
);

  swel_cmd_t  cmd;
  swel_stat_t stat;

  // Controller: sequences dispatch, duplicate check, purge walk and result hand-off.
  swel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: ring memory, oldest and write pointers, count, window and result.
  swel_datapath #(
    .DEPTH (DEPTH),
    .OUT_W (OUT_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (s_tuser),
    .in_minute   (s_tdata[MINUTE_W-1:0]),
    .in_index    (s_tdata[MINUTE_W+INDEX_W-1:MINUTE_W]),
    .cmd         (cmd),
    .stat        (stat),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire
